// ----- src/crlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CR/LF frame extractor package
// Shared types, codes and constants for the frame payload extractor.
// ----------------------------------------------------------------------------
package crlf_pkg;

  localparam int PAYLOAD_BYTES_DEF = 16;
  localparam int RING_DEPTH_DEF    = 256;
  localparam int HDR_TO_PAYLOAD    = 9;
  localparam int IDX_W             = 6;

  localparam logic [7:0] LIMIT_RESET = 8'd10;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_R  = 8'h52;
  localparam logic [7:0] CHAR_B  = 8'h42;
  localparam logic [7:0] CHAR_N  = 8'h4E;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic             result_kind;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic             last;
    logic             link_ok;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic byte_wr;
    logic tick;
    logic scan_start;
    logic scan_step;
    logic emit_start;
    logic emit_rd;
    logic emit_ld;
    logic status_ld;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic hit;
    logic scan_done;
    logic emit_last;
    logic out_full;
  } sts_t;

endpackage

// ----- src/crlf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CR/LF frame extractor controller
// Sequences byte intake, header scan, payload emission and status reports.
// ----------------------------------------------------------------------------
module crlf_ctrl
  import crlf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  input  sts_t     sts,
  output cmd_t     cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_TICK) begin
            cmd.tick   = 1'b1;
            state_next = ST_STATUS;
          end else begin
            cmd.byte_wr = 1'b1;
            if (sts.frame_end) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_RD;
        end else if (sts.scan_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (!sts.out_full) begin
          cmd.emit_rd = 1'b1;
          state_next  = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_STATUS: begin
        if (!sts.out_full) begin
          cmd.status_ld = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/crlf_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CR/LF frame extractor datapath
// Byte ring, backward header window, payload reader, watchdog and output word.
// ----------------------------------------------------------------------------
module crlf_dpath
  import crlf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int RING_DEPTH    = RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  in_word_t   in_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 3);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(RING_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(RING_DEPTH - 1) : a - AW'(1);
  endfunction

  logic [7:0]            mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [AW-1:0]         wr_pos;
  logic [7:0]            prev_byte;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [7:0]            rd_data;

  logic [AW-1:0]         scan_addr;
  logic [AW-1:0]         pend_addr;
  logic [CW-1:0]         issued;
  logic [CW-1:0]         recv;
  logic                  rd_pending;
  logic                  issue_ok;
  logic [7:0]            w0;
  logic [7:0]            w1;
  logic [7:0]            w2;
  logic [AW-1:0]         w0_addr;

  logic [AW-1:0]         em_addr;
  logic [AW:0]           em_sum;
  logic [IDX_W-1:0]      k;

  logic [7:0]            silence_limit;
  logic [7:0]            silence_count;
  logic                  link_flag;

  // Ring write and registered read; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      mem[wr_pos] <= in_data.rx_byte;
    end
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      wr_pos    <= '0;
      prev_byte <= 8'h00;
    end else if (cmd.byte_wr) begin
      vld[wr_pos] <= 1'b1;
      wr_pos      <= wrap_inc(wr_pos);
      prev_byte   <= in_data.rx_byte;
    end
  end

  assign issue_ok = (issued != CW'(RING_DEPTH + 2));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    if (cmd.scan_step && issue_ok) begin
      rd_en = 1'b1;
    end else if (cmd.emit_rd) begin
      rd_en   = 1'b1;
      rd_addr = em_addr;
    end
  end

  // Backward scan: stream reads from LF+2 downward, shift into a 3-byte window.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      issued     <= '0;
      recv       <= '0;
    end else if (cmd.scan_start) begin
      rd_pending <= 1'b0;
      issued     <= '0;
      recv       <= '0;
      scan_addr  <= wrap_inc(wrap_inc(wr_pos));
    end else if (cmd.scan_step) begin
      rd_pending <= issue_ok;
      if (issue_ok) begin
        issued    <= issued + CW'(1);
        scan_addr <= wrap_dec(scan_addr);
        pend_addr <= scan_addr;
      end
      if (rd_pending) begin
        w0      <= rd_data;
        w1      <= w0;
        w2      <= w1;
        w0_addr <= pend_addr;
        recv    <= recv + CW'(1);
      end
    end
  end

  assign em_sum = {1'b0, w0_addr} + (AW + 1)'(HDR_TO_PAYLOAD);

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      em_addr <= (em_sum >= (AW + 1)'(RING_DEPTH)) ? AW'(em_sum - (AW + 1)'(RING_DEPTH))
                                                  : AW'(em_sum);
      k       <= '0;
    end else begin
      if (cmd.emit_rd) begin
        em_addr <= wrap_inc(em_addr);
      end
      if (cmd.emit_ld) begin
        k <= k + IDX_W'(1);
      end
    end
  end

  // Silence watchdog and limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_limit <= LIMIT_RESET;
      silence_count <= LIMIT_RESET;
      link_flag     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        silence_limit <= cfg_wr_data;
      end
      if (cmd.byte_wr) begin
        silence_count <= 8'h00;
      end else if (cmd.tick) begin
        if (silence_count >= silence_limit) begin
          link_flag <= 1'b0;
        end else begin
          link_flag     <= 1'b1;
          silence_count <= silence_count + 8'd1;
        end
      end
    end
  end

  // Output register; loads only when empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld || cmd.status_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_data.result_kind   <= KIND_PAYLOAD;
      out_data.payload_byte  <= rd_data;
      out_data.payload_index <= k;
      out_data.last          <= (k == IDX_W'(PAYLOAD_BYTES - 1));
      out_data.link_ok       <= 1'b0;
    end else if (cmd.status_ld) begin
      out_data.result_kind   <= KIND_STATUS;
      out_data.payload_byte  <= 8'h00;
      out_data.payload_index <= '0;
      out_data.last          <= 1'b0;
      out_data.link_ok       <= link_flag;
    end
  end

  always_comb begin
    sts.frame_end = (prev_byte == CHAR_CR) && (in_data.rx_byte == CHAR_LF);
    sts.hit       = (recv >= CW'(3)) && (w0 == CHAR_R) && (w1 == CHAR_B) && (w2 == CHAR_N);
    sts.scan_done = (recv == CW'(RING_DEPTH + 2));
    sts.emit_last = (k == IDX_W'(PAYLOAD_BYTES - 1));
    sts.out_full  = out_valid;
  end

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_ld || cmd.status_ld) |-> !out_valid)
    else $error("result loaded over a pending word");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld |-> $past(cmd.emit_rd))
    else $error("payload load without a preceding ring read");

  a_pending_src: assert property (@(posedge clk) disable iff (rst)
    (rd_pending && cmd.scan_step) |-> $past(cmd.scan_step || cmd.scan_start) && $past(rd_en))
    else $error("scan window shift without an issued read");

endmodule

// ----- src/crlf_frame_payload_extractor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CR/LF frame payload extractor
// Keeps a ring of received bytes, pulls the payload of each RBN frame on CR LF
// and reports link status from a silence watchdog on every timer tick.
// ----------------------------------------------------------------------------
// A byte without frame end is stored and the block stays idle; a tick loads its
//   status word once the output register is free.
// Frame end: the backward scan reads back through the ring; on an RBN hit each
//   payload byte is read from the ring, then loaded (the output register
//   drains before it reloads). No new input word is taken until this is done.
// Reset clears the sequencer state and the ring valid bits at once; no sweep.
// ----------------------------------------------------------------------------
module crlf_frame_payload_extractor_top
  import crlf_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int RING_DEPTH    = RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  // Command and status between sequencer and datapath.
  cmd_t cmd;
  sts_t sts;

  // Sequencer: take a word in idle, then scan, emit or report.
  crlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: ring, header window, payload reader, watchdog, output register.
  crlf_dpath #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RING_DEPTH    (RING_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
